@@ src/anp_pkg.sv @@
// Shared types and constants for the ASCII decimal/hex number parser.
// No dependencies; used by anp_step and the top level.
package anp_pkg;

  localparam logic [7:0] NoSkipChar = 8'd1;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;
  localparam logic [7:0] CharLowX  = 8'h78;
  localparam logic [7:0] CharUpX   = 8'h58;

  localparam logic [1:0] PosFirst  = 2'd1;
  localparam logic [1:0] PosSecond = 2'd2;
  localparam logic [1:0] PosMax    = 2'd3;

  typedef struct packed {
    logic        in_number;
    logic [31:0] accum;
    logic [1:0]  char_pos;
    logic        first_zero;
    logic        hex_mode;
  } anp_state_t;

  typedef struct packed {
    logic        emit;
    logic [31:0] value;
    logic        found;
  } anp_result_t;

  localparam anp_state_t StateClear = '{
    in_number:  1'b0,
    accum:      32'd0,
    char_pos:   2'd0,
    first_zero: 1'b0,
    hex_mode:   1'b0
  };

endpackage

@@ src/anp_step.sv @@
// One parser step: next state and optional result from the current state,
// one registered word and the skip character. Depends on anp_pkg.
module anp_step (
  input  anp_pkg::anp_state_t  state_i,
  input  logic [7:0]           ch_i,
  input  logic                 eod_i,
  input  logic [7:0]           skip_char_i,
  output anp_pkg::anp_state_t  state_o,
  output anp_pkg::anp_result_t result_o
);
  import anp_pkg::*;

  logic       is_dec;
  logic       is_lo_hex;
  logic       is_up_hex;
  logic       is_digit;
  logic [3:0] digit;
  logic       is_skip;
  logic       is_x;
  logic [1:0] pos_next;
  logic [31:0] accum_dec;
  logic [31:0] accum_hex;

  assign is_dec    = (ch_i >= CharZero) && (ch_i <= CharNine);
  assign is_lo_hex = (ch_i >= CharLowA) && (ch_i <= CharLowF);
  assign is_up_hex = (ch_i >= CharUpA) && (ch_i <= CharUpF);
  assign is_digit  = is_dec || (state_i.hex_mode && (is_lo_hex || is_up_hex));
  assign is_skip   = (ch_i == skip_char_i);
  assign is_x      = (ch_i == CharLowX) || (ch_i == CharUpX);
  assign pos_next  = (state_i.char_pos == PosMax) ? PosMax : state_i.char_pos + 2'd1;

  always_comb begin
    if (is_dec) begin
      digit = 4'(ch_i - CharZero);
    end else if (is_lo_hex) begin
      digit = 4'(ch_i - CharLowA + 8'd10);
    end else begin
      digit = 4'(ch_i - CharUpA + 8'd10);
    end
  end

  // x10 as x8 + x2, x16 as a shift
  assign accum_dec = {state_i.accum[28:0], 3'b000} + {state_i.accum[30:0], 1'b0}
                   + {28'd0, digit};
  assign accum_hex = {state_i.accum[27:0], digit};

  always_comb begin
    state_o        = state_i;
    result_o.emit  = 1'b0;
    result_o.value = state_i.accum;
    result_o.found = 1'b1;
    if (eod_i) begin
      result_o.emit  = 1'b1;
      result_o.value = state_i.in_number ? state_i.accum : 32'd0;
      result_o.found = state_i.in_number;
      state_o        = StateClear;
    end else if (!state_i.in_number) begin
      if (is_dec) begin
        state_o            = StateClear;
        state_o.in_number  = 1'b1;
        state_o.char_pos   = PosFirst;
        // a skipped first digit only opens the number
        if (!is_skip) begin
          state_o.first_zero = (ch_i == CharZero);
          state_o.accum      = {28'd0, digit};
        end
      end
    end else begin
      state_o.char_pos = pos_next;
      if (is_skip) begin
        state_o.char_pos = pos_next;
      end else if ((pos_next == PosSecond) && state_i.first_zero && is_x) begin
        state_o.hex_mode = 1'b1;
      end else if (!is_digit) begin
        result_o.emit = 1'b1;
        state_o       = StateClear;
      end else begin
        state_o.accum = state_i.hex_mode ? accum_hex : accum_dec;
      end
    end
  end

endmodule

@@ src/ascii_dec_hex_number_parser_unit.sv @@
// Top level of the ASCII decimal/hex number parser: input register, parser
// state, result register. Depends on anp_pkg and anp_step.
//
// Takes one character word per cycle on the slave stream and delivers one word
// on the master stream per closed number or end-of-data mark. Sustained rate
// is one word per cycle unless a result stalls; the shift-add parser state
// register updates per word, which passes from the input register through
// anp_step to the result register. The input side stalls only while a result
// waits and the current word would make another one. The user writes skip_char
// via cfg_we_i/cfg_wdata_i only while idle, not enforced here; it resets to 1.
module ascii_dec_hex_number_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,   // skip_char
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] ch
  input  logic        s_axis_tuser,  // [0] end_of_data
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] value
  output logic        m_axis_tuser   // [0] number_found
);
  import anp_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_ch_q;
  logic        in_eod_q;
  logic [7:0]  skip_q;
  anp_state_t  state_q;
  anp_state_t  state_d;
  anp_result_t result;
  logic        out_valid_q;
  logic [31:0] out_value_q;
  logic        out_found_q;
  logic        out_free;
  logic        advance;

  anp_step u_step (
    .state_i     (state_q),
    .ch_i        (in_ch_q),
    .eod_i       (in_eod_q),
    .skip_char_i (skip_q),
    .state_o     (state_d),
    .result_o    (result)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (out_free || !result.emit);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= NoSkipChar;
    end else if (cfg_we_i) begin
      skip_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_ch_q  <= s_axis_tdata;
      in_eod_q <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateClear;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && result.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result.emit) begin
      out_value_q <= result.value;
      out_found_q <= result.found;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_found_q;

endmodule

@@ src/anp_checker.sv @@
// Port-level checks for the number parser top level, bound to it below.
// Depends only on the top level's ports.
module anp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result word changed");

  // a not-found word always carries zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'd0)
    else $error("not-found word with nonzero value");

  // input back-pressure only while a result is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output stall");

  // with the output free, an input stall ends once the output accepts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready && m_axis_tready |=> s_axis_tready)
    else $error("input stall outlasted output release");

endmodule

bind ascii_dec_hex_number_parser_unit anp_checker u_anp_checker (.*);
